// File: rtl/integer_to_ascii_converter_macros.svh
// Assertion macros for the integer to ASCII converter.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef INTEGER_TO_ASCII_CONVERTER_MACROS_SVH
`define INTEGER_TO_ASCII_CONVERTER_MACROS_SVH

// Plain property, sampled on clk_i, off while in reset.
`define I2A_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define I2A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/i2a_pkg.sv
// Shared constants, types and the digit-to-ASCII function of the converter.
// No dependencies.
package i2a_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int CMD_W       = 2;
  localparam int CHAR_W      = 8;

  // Decimal digits of a VALUE_WIDTH-bit number: floor(W * log10(2)) + 1.
  localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int DIGITS     = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int DIG_BITS   = 4 * DIGITS;

  localparam logic [CMD_W-1:0] CMD_SDEC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UDEC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_HEXL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_HEXU = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [3:0]        DEC_BASE   = 4'd10;

  typedef enum logic [2:0] {
    DIG_HOLD,
    DIG_CLEAR,
    DIG_LOAD,
    DIG_DABBLE,
    DIG_SHIFT
  } dig_op_e;

  typedef struct packed {
    dig_op_e op;
    logic    bit_in;
  } dig_ctrl_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CHAR_UPPER : CHAR_LOWER;
    if (d < DEC_BASE) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return base + CHAR_W'(d - DEC_BASE);
  endfunction

endpackage

// File: rtl/i2a_if.sv
// Handshake channels of the converter: input item and output character.
// Depends on i2a_pkg.
interface i2a_in_if;
  logic                             valid;
  logic                             ready;
  logic [i2a_pkg::CMD_W-1:0]        command;
  logic [i2a_pkg::VALUE_WIDTH-1:0]  value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface i2a_out_if;
  logic                        valid;
  logic                        ready;
  logic [i2a_pkg::CHAR_W-1:0]  character;
  logic                        last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

// File: rtl/integer_to_ascii_converter.sv
// Integer to ASCII converter: one character beat per handshake. Uses i2a_pkg, i2a_if,
// i2a_digit_reg and the macros header.
// After accept, hex goes straight to leading-zero skip and digit output; decimal first runs
// the serial BCD pass, and negative decimal runs the serial negate before that. Output stalls lengthen it.
// One number at a time: a new item is taken only in IDLE, after the last digit beat is registered.
// Reset: rst_ni asynchronous, active low; clears the sequencer and the output beat.
`include "integer_to_ascii_converter_macros.svh"

module integer_to_ascii_converter (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2a_in_if.sink        in_i,
  i2a_out_if.source     out_o
);

  localparam int W      = i2a_pkg::VALUE_WIDTH;
  localparam int CNT_W  = $clog2(W);
  localparam int DCNT_W = $clog2(i2a_pkg::DIGITS + 1);

  // IDLE: take an item. NEG: serial two's complement. CONV: shift-add-3.
  // SIGN: emit '-'. SKIP: drop leading zero digits. EMIT: digits out.
  typedef enum logic [2:0] {
    IDLE,
    NEG,
    CONV,
    SIGN,
    SKIP,
    EMIT
  } state_e;

  state_e                     state_q;
  logic [i2a_pkg::CMD_W-1:0]  cmd_q;
  logic [W-1:0]               val_q;
  logic                       neg_q;
  logic                       seen_q;   // a one has passed the negate stage
  logic [CNT_W-1:0]           cnt_q;
  logic [DCNT_W-1:0]          dig_cnt_q;
  logic                       out_valid_q;
  logic [i2a_pkg::CHAR_W-1:0] out_char_q;
  logic                       out_last_q;

  logic               accept, slot_free, in_neg, in_hex, cnt_end, skip_zero;
  logic [3:0]         top_dig;
  i2a_pkg::dig_ctrl_t dig_ctrl;

  assign in_i.ready = (state_q == IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign in_hex     = (in_i.command == i2a_pkg::CMD_HEXL) || (in_i.command == i2a_pkg::CMD_HEXU);
  assign in_neg     = (in_i.command == i2a_pkg::CMD_SDEC) && in_i.value[W-1];
  assign cnt_end    = (cnt_q == CNT_W'(W - 1));
  // the output register frees up when empty or when its beat is taken now
  assign slot_free  = !out_valid_q || out_o.ready;
  // always keep at least one digit, so zero prints as '0'
  assign skip_zero  = (top_dig == 4'd0) && (dig_cnt_q > DCNT_W'(1));

  assign out_o.valid     = out_valid_q;
  assign out_o.character = out_char_q;
  assign out_o.last      = out_last_q;

  // digit register control
  always_comb begin
    dig_ctrl.op     = i2a_pkg::DIG_HOLD;
    dig_ctrl.bit_in = val_q[W-1];
    unique case (state_q)
      IDLE: begin
        if (accept) begin
          if (in_hex) begin
            dig_ctrl.op = i2a_pkg::DIG_LOAD;
          end else if (!in_neg) begin
            dig_ctrl.op = i2a_pkg::DIG_CLEAR;
          end
        end
      end
      NEG: begin
        if (cnt_end) begin
          dig_ctrl.op = i2a_pkg::DIG_CLEAR;
        end
      end
      CONV: dig_ctrl.op = i2a_pkg::DIG_DABBLE;
      SIGN: dig_ctrl.op = i2a_pkg::DIG_HOLD;
      SKIP: begin
        if (skip_zero) begin
          dig_ctrl.op = i2a_pkg::DIG_SHIFT;
        end
      end
      EMIT: begin
        if (slot_free) begin
          dig_ctrl.op = i2a_pkg::DIG_SHIFT;
        end
      end
    endcase
  end

  i2a_digit_reg u_digits (
    .clk_i  (clk_i),
    .ctrl_i (dig_ctrl),
    .load_i (in_i.value),
    .top_o  (top_dig)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      cmd_q       <= i2a_pkg::CMD_SDEC;
      val_q       <= '0;
      neg_q       <= 1'b0;
      seen_q      <= 1'b0;
      cnt_q       <= '0;
      dig_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        IDLE: begin
          if (accept) begin
            cmd_q     <= in_i.command;
            val_q     <= in_i.value;
            neg_q     <= in_neg;
            seen_q    <= 1'b0;
            cnt_q     <= '0;
            dig_cnt_q <= DCNT_W'(i2a_pkg::DIGITS);
            if (in_hex) begin
              state_q <= SKIP;
            end else if (in_neg) begin
              state_q <= NEG;
            end else begin
              state_q <= CONV;
            end
          end
        end
        NEG: begin
          // rotate right; copy up to the first one, invert after it
          val_q  <= {val_q[0] ^ seen_q, val_q[W-1:1]};
          seen_q <= seen_q | val_q[0];
          cnt_q  <= cnt_end ? '0 : cnt_q + CNT_W'(1);
          if (cnt_end) begin
            state_q <= CONV;
          end
        end
        CONV: begin
          val_q <= {val_q[W-2:0], 1'b0};
          cnt_q <= cnt_end ? '0 : cnt_q + CNT_W'(1);
          if (cnt_end) begin
            state_q <= neg_q ? SIGN : SKIP;
          end
        end
        SIGN: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_char_q  <= i2a_pkg::CHAR_MINUS;
            out_last_q  <= 1'b0;
            state_q     <= SKIP;
          end
        end
        SKIP: begin
          if (skip_zero) begin
            dig_cnt_q <= dig_cnt_q - DCNT_W'(1);
          end else begin
            state_q <= EMIT;
          end
        end
        EMIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_char_q  <= i2a_pkg::digit_char(top_dig, cmd_q == i2a_pkg::CMD_HEXU);
            out_last_q  <= (dig_cnt_q == DCNT_W'(1));
            dig_cnt_q   <= dig_cnt_q - DCNT_W'(1);
            if (dig_cnt_q == DCNT_W'(1)) begin
              state_q <= IDLE;
            end
          end
        end
      endcase
    end
  end

  // digit count stays within the register while digits go out
  `I2A_ASSERT(a_dig_cnt_range,
    (state_q != EMIT) ||
    ((dig_cnt_q >= DCNT_W'(1)) && (dig_cnt_q <= DCNT_W'(i2a_pkg::DIGITS))),
    "digit count out of range")
  // sign beat is never the final one
  `I2A_ASSERT_NEXT(a_sign_first, (state_q == SIGN) && slot_free,
    out_o.valid && (out_o.character == i2a_pkg::CHAR_MINUS) && !out_o.last,
    "sign beat malformed")
  // the final digit ends the number and flags last
  `I2A_ASSERT_NEXT(a_last_final,
    (state_q == EMIT) && slot_free && (dig_cnt_q == DCNT_W'(1)),
    (state_q == IDLE) && out_o.valid && out_o.last, "last digit not flagged")
  // conversion only leaves toward output
  `I2A_ASSERT_NEXT(a_conv_exit, state_q == CONV,
    (state_q == CONV) || (state_q == SIGN) || (state_q == SKIP), "bad exit from conversion")

endmodule

// File: rtl/i2a_digit_reg.sv
// Nibble shift register: shift-add-3 binary to BCD, hex load, digit shift-out.
// Depends on i2a_pkg.
module i2a_digit_reg (
  input  logic                            clk_i,
  input  i2a_pkg::dig_ctrl_t              ctrl_i,
  input  logic [i2a_pkg::VALUE_WIDTH-1:0] load_i,
  output logic [3:0]                      top_o
);

  logic [i2a_pkg::DIG_BITS-1:0] dig_q, dig_d, adj;

  // add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < i2a_pkg::DIGITS; i++) begin
      adj[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ? dig_q[4*i +: 4] + 4'd3 : dig_q[4*i +: 4];
    end
  end

  always_comb begin
    unique case (ctrl_i.op)
      i2a_pkg::DIG_HOLD:   dig_d = dig_q;
      i2a_pkg::DIG_CLEAR:  dig_d = '0;
      i2a_pkg::DIG_LOAD:   dig_d = i2a_pkg::DIG_BITS'(load_i);
      i2a_pkg::DIG_DABBLE: dig_d = {adj[i2a_pkg::DIG_BITS-2:0], ctrl_i.bit_in};
      i2a_pkg::DIG_SHIFT:  dig_d = {dig_q[i2a_pkg::DIG_BITS-5:0], 4'd0};
      default:             dig_d = dig_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
  end

  assign top_o = dig_q[i2a_pkg::DIG_BITS-1 -: 4];

endmodule
